>>> hdl/ddm_pkg.sv
// ----------------------------------------------------------------------------
// ddm_pkg
// shared types and constants of the decimal digit multiplier
// ----------------------------------------------------------------------------
package ddm_pkg;

    // default operand capacity in digits
    localparam int MAX_DIGITS_DEF = 32;

    // command codes
    localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [1:0] OP_RUN         = 2'd2;

    // largest decimal digit, loads saturate here
    localparam logic [3:0] DIGIT_MAX = 4'd9;

    // floor(2^16 / 10), estimate of v / 10 that is never low by more than one
    localparam int RECIP_10    = 6553;
    localparam int RECIP_SHIFT = 16;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] digit;
    } t_in_item;

    typedef struct packed {
        logic [3:0] product_digit;
        logic       last;
        logic       overflow;
    } t_out_item;

endpackage

>>> hdl/decimal_digit_multiplier.sv
// ----------------------------------------------------------------------------
// decimal_digit_multiplier
// exact product of two decimal numbers, loaded and emitted one digit at a time
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_stall / i_in_item): each transaction is a
//   command. load first and load second append one digit (msd first) to an
//   operand. run forms the product and emits it on the
//   output channel (o_out_valid / i_out_stall / o_out_item), msd first, no
//   leading zeros, at least one digit, last set on the final digit. run clears
//   both operands and the overflow flag.
// run sequence
//   the product is built one column at a time, least significant first, with
//   one digit multiply per cycle (S_MAC), then S_WAIT, S_DIV1 and S_DIV2 per
//   column; the top column holds only carry and runs S_DIV1, S_DIV2 only. each
//   product digit then passes S_EREAD, S_ELOAD and S_EWAIT, msd first. the
//   single read port of each operand store sets the pace.
//   o_in_stall is high for the whole run.
// reset
//   synchronous, active low: operand counts and overflow clear, output idles.
//   digit stores are not cleared; only written entries are ever read.
// stall
//   a pending product digit holds in the output register until taken.
// ----------------------------------------------------------------------------
module decimal_digit_multiplier #(
    parameter int MAX_DIGITS = ddm_pkg::MAX_DIGITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ddm_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ddm_pkg::t_out_item o_out_item
);
    import ddm_pkg::*;

    // widths derived from capacity
    localparam int PD = 2 * MAX_DIGITS;                       // product digits
    localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CW = $clog2(MAX_DIGITS + 1);               // digit count
    localparam int PW = $clog2(PD);                           // product index
    localparam int XW = PW + 1;                               // index arithmetic
    localparam int VW = $clog2(MAX_DIGITS * 90 + 1);          // column sum + carry
    localparam int MW = VW + RECIP_SHIFT;                     // reciprocal product

    typedef enum logic [3:0] {
        S_IDLE, S_ZERO, S_MAC, S_WAIT, S_DIV1, S_DIV2, S_EREAD, S_ELOAD, S_EWAIT
    } t_state;

    t_state r_state;

    // operand and product stores
    logic [3:0] mem_a [MAX_DIGITS];
    logic [3:0] mem_b [MAX_DIGITS];
    logic [3:0] mem_p [PD];

    logic [CW-1:0] r_cnt_a, r_cnt_b;
    logic          r_ovf;

    // column engine
    logic [PW-1:0] r_k;          // current column
    logic [AW-1:0] r_i;          // first-operand digit index within column
    logic          r_mac_vld;    // operand data arriving this cycle
    logic [3:0]    r_a_dat, r_b_dat;
    logic [VW-1:0] r_acc, r_carry, r_v, r_q;
    logic [PW-1:0] r_top;        // highest nonzero product digit so far
    logic [PW-1:0] r_e;          // emit index
    logic [3:0]    r_pd;

    t_out_item r_out;
    logic      r_out_vld;

    // input side
    logic          in_acc;
    logic [3:0]    sat_digit;
    logic          load_a, load_b, run_cmd;

    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign sat_digit = (i_in_item.digit > DIGIT_MAX) ? DIGIT_MAX : i_in_item.digit;
    assign load_a    = in_acc && (i_in_item.op == OP_LOAD_FIRST)
                       && (r_cnt_a != CW'(MAX_DIGITS));
    assign load_b    = in_acc && (i_in_item.op == OP_LOAD_SECOND)
                       && (r_cnt_b != CW'(MAX_DIGITS));
    assign run_cmd   = in_acc && (i_in_item.op == OP_RUN);

    // column bounds: terms i in [lo, hi], j = k - i
    logic [XW-1:0] n1, n2, len_m1, k_x, k_nx, i_x, i_hi, lo_next;
    logic [XW-1:0] a_addr_x, b_addr_x;
    logic          last_term;

    always_comb begin
        n1       = XW'(r_cnt_a);
        n2       = XW'(r_cnt_b);
        len_m1   = n1 + n2 - XW'(1);
        k_x      = XW'(r_k);
        k_nx     = k_x + XW'(1);
        i_x      = XW'(r_i);
        i_hi     = (k_x < n1 - XW'(1)) ? k_x : n1 - XW'(1);
        lo_next  = (k_nx >= n2) ? k_nx - n2 + XW'(1) : '0;
        a_addr_x = n1 - XW'(1) - i_x;
        b_addr_x = n2 - XW'(1) - (k_x - i_x);
        last_term = (i_x == i_hi);
    end

    // divide by ten: reciprocal estimate, then one correction step
    logic [VW-1:0] col_v;
    logic [MW-1:0] recip_mul;
    logic [VW-1:0] rem_raw, rem_fix, q_fix;
    logic [3:0]    digit_out;
    logic [PW-1:0] top_next;

    always_comb begin
        col_v     = r_acc + r_carry;
        recip_mul = MW'(col_v) * MW'(RECIP_10);
        rem_raw   = r_v - ((r_q << 3) + (r_q << 1));
        if (rem_raw >= VW'(10)) begin
            rem_fix = rem_raw - VW'(10);
            q_fix   = r_q + VW'(1);
        end else begin
            rem_fix = rem_raw;
            q_fix   = r_q;
        end
        digit_out = rem_fix[3:0];
        top_next  = (digit_out != 4'd0) ? r_k : r_top;
    end

    // operand stores: one write on load, one registered read per cycle in S_MAC
    always_ff @(posedge i_clk) begin
        if (load_a) begin
            mem_a[r_cnt_a[AW-1:0]] <= sat_digit;
        end
        if (r_state == S_MAC) begin
            r_a_dat <= mem_a[a_addr_x[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_b) begin
            mem_b[r_cnt_b[AW-1:0]] <= sat_digit;
        end
        if (r_state == S_MAC) begin
            r_b_dat <= mem_b[b_addr_x[AW-1:0]];
        end
    end

    // product store: written per finished column, read during emission
    always_ff @(posedge i_clk) begin
        if (r_state == S_ZERO) begin
            mem_p[0] <= 4'd0;
        end else if (r_state == S_DIV2) begin
            mem_p[r_k] <= digit_out;
        end
        if (r_state == S_EREAD) begin
            r_pd <= mem_p[r_e];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt_a   <= '0;
            r_cnt_b   <= '0;
            r_ovf     <= 1'b0;
            r_mac_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_mac_vld <= (r_state == S_MAC);
            if (r_mac_vld) begin
                r_acc <= r_acc + VW'(r_a_dat) * VW'(r_b_dat);
            end

            case (r_state)
                S_IDLE: begin
                    if (load_a) begin
                        r_cnt_a <= r_cnt_a + CW'(1);
                    end
                    if (load_b) begin
                        r_cnt_b <= r_cnt_b + CW'(1);
                    end
                    if (in_acc && (i_in_item.op == OP_LOAD_FIRST ||
                                   i_in_item.op == OP_LOAD_SECOND) &&
                        !load_a && !load_b) begin
                        r_ovf <= 1'b1;     // store full, digit dropped
                    end
                    if (run_cmd) begin
                        r_k     <= '0;
                        r_i     <= '0;
                        r_acc   <= '0;
                        r_carry <= '0;
                        r_top   <= '0;
                        if (r_cnt_a == '0 || r_cnt_b == '0) begin
                            r_state <= S_ZERO;
                        end else begin
                            r_state <= S_MAC;
                        end
                    end
                end
                S_ZERO: begin
                    r_e     <= '0;
                    r_state <= S_EREAD;
                end
                S_MAC: begin
                    if (last_term) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_i <= r_i + AW'(1);
                    end
                end
                S_WAIT: begin
                    r_state <= S_DIV1;   // last product lands in acc
                end
                S_DIV1: begin
                    r_v     <= col_v;
                    r_q     <= recip_mul[RECIP_SHIFT +: VW];
                    r_state <= S_DIV2;
                end
                S_DIV2: begin
                    r_carry <= q_fix;
                    r_top   <= top_next;
                    r_acc   <= '0;
                    if (k_x == len_m1) begin
                        r_e     <= top_next;
                        r_state <= S_EREAD;
                    end else begin
                        r_k <= r_k + PW'(1);
                        if (k_nx == len_m1) begin
                            r_state <= S_DIV1;   // top column holds only carry
                        end else begin
                            r_i     <= lo_next[AW-1:0];
                            r_state <= S_MAC;
                        end
                    end
                end
                S_EREAD: begin
                    r_state <= S_ELOAD;
                end
                S_ELOAD: begin
                    r_out.product_digit <= r_pd;
                    r_out.last          <= (r_e == '0);
                    r_out.overflow      <= r_ovf;
                    r_out_vld           <= 1'b1;
                    r_state             <= S_EWAIT;
                end
                S_EWAIT: begin
                    if (!i_out_stall) begin
                        r_out_vld <= 1'b0;
                        if (r_e == '0) begin
                            r_cnt_a <= '0;
                            r_cnt_b <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_e     <= r_e - PW'(1);
                            r_state <= S_EREAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule
